@@ design/crtc_pkg.sv @@
// crtc_pkg: codes and register indexes for the CRT controller register bank.
// No dependencies; referenced by vga_crtc_register_bank.
`default_nettype none

package crtc_pkg;

    localparam int NUM_REGS = 25;
    localparam int ADDR_W   = 5;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_action;

    // bus actions
    localparam t_action ACT_WR_INDEX = 2'd0;
    localparam t_action ACT_RD_INDEX = 2'd1;
    localparam t_action ACT_WR_DATA  = 2'd2;
    localparam t_action ACT_RD_DATA  = 2'd3;

    // adapter codes
    localparam logic [1:0] ARCH_OTHER = 2'd0;
    localparam logic [1:0] ARCH_EGA   = 2'd1;
    localparam logic [1:0] ARCH_VGA   = 2'd2;

    // resize request codes
    localparam logic [1:0] RS_NONE     = 2'd0;
    localparam logic [1:0] RS_NOW      = 2'd1;
    localparam logic [1:0] RS_DEFERRED = 2'd2;

    // address shift codes
    localparam logic [1:0] SHIFT_BYTE  = 2'd0;
    localparam logic [1:0] SHIFT_WORD  = 2'd1;
    localparam logic [1:0] SHIFT_DWORD = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ARCH_MODE   = 2'd0;
    localparam logic [1:0] CFG_IGNORE_HDE  = 2'd1;
    localparam logic [1:0] CFG_DOUBLESCAN  = 2'd2;

    // CRTC data register indexes
    localparam t_byte IDX_HDE       = 8'd1;
    localparam t_byte IDX_VTOTAL    = 8'd6;
    localparam t_byte IDX_OVERFLOW  = 8'd7;
    localparam t_byte IDX_ROW_SCAN  = 8'd8;
    localparam t_byte IDX_MAX_SCAN  = 8'd9;
    localparam t_byte IDX_CUR_START = 8'd10;
    localparam t_byte IDX_START_HI  = 8'd12;
    localparam t_byte IDX_START_LO  = 8'd13;
    localparam t_byte IDX_CUR_HI    = 8'd14;
    localparam t_byte IDX_CUR_LO    = 8'd15;
    localparam t_byte IDX_VRET_END  = 8'd17;
    localparam t_byte IDX_VDE       = 8'd18;
    localparam t_byte IDX_UNDERLINE = 8'd20;
    localparam t_byte IDX_VBLK_ST   = 8'd21;
    localparam t_byte IDX_VBLK_END  = 8'd22;
    localparam t_byte IDX_MODE_CTL  = 8'd23;
    localparam t_byte IDX_LINE_CMP  = 8'd24;
    localparam t_byte IDX_PROT_LAST = 8'd7;

    // bit masks
    localparam t_byte OVF_RESIZE_MASK = 8'hD6;
    localparam t_byte MSL_DS_MASK     = 8'h81;
    localparam t_byte MSL_BASE_MASK   = 8'h20;
    localparam t_byte EGA_MSL_MASK    = 8'h7F;

endpackage

`default_nettype wire

@@ design/vga_crtc_register_bank.sv @@
// vga_crtc_register_bank: indexed CRT controller register file with decoded outputs.
// Depends on crtc_pkg (codes, register indexes, masks).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one bus access word:
//   i_action (write index, read index, write data, read data) and
//   i_write_data. Every accepted word yields exactly one result word on
//   the output channel (o_out_valid / i_out_ready): read data, resize
//   request, retrace-clear pulse, unknown-index flag, and the decoded
//   CRTC values as they stand after the access.
//   The 25 data registers sit in a synchronous RAM. A word is taken in
//   IDLE and its register is read on that edge; then, in EXEC, it is
//   modified, written back and the result register is loaded. The result
//   is valid and the input is ready again once EXEC finishes, so a new
//   word is taken only after the last has left EXEC; the RAM read sets this.
//   If the receiver stalls, one more word can be accepted; it waits in
//   EXEC, with input ready low, until the result register frees up.
//   Config port (i_cfg_valid / o_cfg_ready, always ready) writes arch
//   mode, ignore-HDE-shrink and doublescan-set; write it only when idle.
//   Reset: all data registers read 0 (per-entry valid bits, cleared at
//   once, no clearing pass), index 0, shift 1, line total 1, cursor on,
//   arch mode VGA.
`default_nettype none

module vga_crtc_register_bank (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // bus access channel
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_action,
    input  wire  [7:0]  i_write_data,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_read_data,
    output logic [1:0]  o_resize_request,
    output logic        o_retrace_clear,
    output logic [15:0] o_start_addr,
    output logic [15:0] o_cursor_address,
    output logic [9:0]  o_split_line,
    output logic [1:0]  o_addr_mode,
    output logic [6:0]  o_row_lines,
    output logic [4:0]  o_row_scan_skip,
    output logic [1:0]  o_byte_skip,
    output logic        o_cursor_enabled,
    output logic        o_unknown_index,
    // configuration write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // control
    logic        r_state;
    logic        r_out_valid;
    logic [1:0]  r_action;
    logic [7:0]  r_wdata;

    // register file: RAM plus valid bits
    logic [7:0]  r_mem [0:crtc_pkg::NUM_REGS-1];
    logic [crtc_pkg::NUM_REGS-1:0] r_vld;
    logic [7:0]  r_mem_q;
    logic        r_mem_q_vld;

    // index, protect, shadows of the shift-select bits
    logic [7:0]  r_index;
    logic        r_wprot;
    logic        r_u20_b6;
    logic        r_m23_b6;

    // config
    logic [1:0]  r_arch;
    logic        r_ign_hde;
    logic        r_dscan;

    // decoded state
    logic [15:0] r_start;
    logic [15:0] r_cursor;
    logic [9:0]  r_lcmp;
    logic [1:0]  r_shift;
    logic [6:0]  r_ltotal;
    logic [4:0]  r_rskip;
    logic [1:0]  r_bskip;
    logic        r_cur_on;

    // result word
    logic [7:0]  r_rd;
    logic [1:0]  r_rs;
    logic        r_clr;
    logic        r_unk;

    // next values
    logic [7:0]  n_index;
    logic        n_wprot;
    logic        n_u20_b6;
    logic        n_m23_b6;
    logic [15:0] n_start;
    logic [15:0] n_cursor;
    logic [9:0]  n_lcmp;
    logic [1:0]  n_shift;
    logic [6:0]  n_ltotal;
    logic [4:0]  n_rskip;
    logic [1:0]  n_bskip;
    logic        n_cur_on;
    logic [7:0]  n_rd;
    logic [1:0]  n_rs;
    logic        n_clr;
    logic        n_unk;
    logic        n_mem_we;
    logic [7:0]  n_mem_wd;

    logic        in_accept;
    logic        exec_done;
    logic        idx_ok;
    logic [crtc_pkg::ADDR_W-1:0] addr;
    logic [7:0]  old_val;
    logic        is_vga;
    logic        is_egavga;

    assign in_accept = i_in_valid && o_in_ready;
    assign exec_done = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
    assign idx_ok    = (r_index < 8'(crtc_pkg::NUM_REGS));
    assign addr      = r_index[crtc_pkg::ADDR_W-1:0];
    assign old_val   = r_mem_q_vld ? r_mem_q : 8'h00;
    assign is_vga    = (r_arch == crtc_pkg::ARCH_VGA);
    assign is_egavga = (r_arch == crtc_pkg::ARCH_VGA) || (r_arch == crtc_pkg::ARCH_EGA);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // read-modify-write of the addressed register
    always_comb begin
        logic [7:0] v;
        logic [7:0] chk;
        logic [7:0] diff;
        logic [6:0] tot;

        v        = r_wdata;
        chk      = crtc_pkg::MSL_BASE_MASK;
        diff     = 8'h00;
        tot      = 7'd0;
        n_index  = r_index;
        n_wprot  = r_wprot;
        n_u20_b6 = r_u20_b6;
        n_m23_b6 = r_m23_b6;
        n_start  = r_start;
        n_cursor = r_cursor;
        n_lcmp   = r_lcmp;
        n_shift  = r_shift;
        n_ltotal = r_ltotal;
        n_rskip  = r_rskip;
        n_bskip  = r_bskip;
        n_cur_on = r_cur_on;
        n_rd     = 8'h00;
        n_rs     = crtc_pkg::RS_NONE;
        n_clr    = 1'b0;
        n_unk    = 1'b0;
        n_mem_we = 1'b0;
        n_mem_wd = v;

        case (r_action)
            crtc_pkg::ACT_WR_INDEX: begin
                n_index = r_wdata;
            end
            crtc_pkg::ACT_RD_INDEX: begin
                n_rd = r_index;
            end
            crtc_pkg::ACT_RD_DATA: begin
                if (idx_ok) begin
                    n_rd = old_val;
                end else begin
                    n_unk = 1'b1;
                end
            end
            default: begin // data write
                if (!idx_ok) begin
                    n_unk = 1'b1;
                end else if (r_index <= crtc_pkg::IDX_PROT_LAST) begin
                    // line compare bit 8 bypasses write protect
                    if (r_index == crtc_pkg::IDX_OVERFLOW) begin
                        n_lcmp[8] = v[4];
                    end
                    if (!r_wprot) begin
                        n_mem_we = 1'b1;
                        if (r_index == crtc_pkg::IDX_HDE) begin
                            if (v != old_val && !(r_ign_hde && v < old_val)) begin
                                n_rs = crtc_pkg::RS_NOW;
                            end
                        end else if (r_index == crtc_pkg::IDX_VTOTAL) begin
                            if (v != old_val) begin
                                n_rs = crtc_pkg::RS_NOW;
                            end
                        end else if (r_index == crtc_pkg::IDX_OVERFLOW) begin
                            if (((old_val ^ v) & crtc_pkg::OVF_RESIZE_MASK) != 8'h00) begin
                                n_rs = crtc_pkg::RS_NOW;
                            end
                        end
                    end
                end else begin
                    n_mem_we = 1'b1;
                    if (r_index == crtc_pkg::IDX_ROW_SCAN) begin
                        n_rskip = v[4:0];
                        n_bskip = is_vga ? v[6:5] : 2'd0;
                    end else if (r_index == crtc_pkg::IDX_MAX_SCAN) begin
                        if (is_vga) begin
                            n_lcmp[9] = v[6];
                        end else if (r_arch == crtc_pkg::ARCH_EGA) begin
                            v = v & crtc_pkg::EGA_MSL_MASK;
                        end
                        if (!r_dscan) begin
                            chk = chk | crtc_pkg::MSL_DS_MASK;
                        end
                        if (((old_val ^ v) & chk) != 8'h00) begin
                            n_rs = crtc_pkg::RS_NOW;
                        end
                        tot      = {2'b00, v[4:0]} + 7'd1;
                        n_ltotal = v[7] ? {tot[5:0], 1'b0} : tot;
                        n_mem_wd = v;
                    end else if (r_index == crtc_pkg::IDX_CUR_START) begin
                        n_cur_on = is_vga ? !v[5] : 1'b1;
                    end else if (r_index == crtc_pkg::IDX_START_HI) begin
                        n_start[15:8] = v;
                    end else if (r_index == crtc_pkg::IDX_START_LO) begin
                        n_start[7:0] = v;
                    end else if (r_index == crtc_pkg::IDX_CUR_HI) begin
                        n_cursor[15:8] = v;
                    end else if (r_index == crtc_pkg::IDX_CUR_LO) begin
                        n_cursor[7:0] = v;
                    end else if (r_index == crtc_pkg::IDX_VRET_END) begin
                        n_clr   = is_egavga && !v[4];
                        n_wprot = is_vga && v[7];
                    end else if (r_index == crtc_pkg::IDX_VDE) begin
                        if (v != old_val) begin
                            diff = (v > old_val) ? (v - old_val) : (old_val - v);
                            n_rs = (diff < 8'd3) ? crtc_pkg::RS_DEFERRED : crtc_pkg::RS_NOW;
                        end
                    end else if (r_index inside {crtc_pkg::IDX_VBLK_ST,
                                                 crtc_pkg::IDX_VBLK_END}) begin
                        if (v != old_val) begin
                            n_rs = crtc_pkg::RS_NOW;
                        end
                    end else if (r_index == crtc_pkg::IDX_LINE_CMP) begin
                        n_lcmp[7:0] = v;
                    end
                    // address shift follows registers 20 and 23
                    if (r_index inside {crtc_pkg::IDX_UNDERLINE, crtc_pkg::IDX_MODE_CTL}) begin
                        if (r_index == crtc_pkg::IDX_UNDERLINE) begin
                            n_u20_b6 = v[6];
                        end else begin
                            n_m23_b6 = v[6];
                        end
                        if (is_vga && n_u20_b6) begin
                            n_shift = crtc_pkg::SHIFT_DWORD;
                        end else if (is_egavga && n_m23_b6) begin
                            n_shift = crtc_pkg::SHIFT_BYTE;
                        end else begin
                            n_shift = crtc_pkg::SHIFT_WORD;
                        end
                    end
                end
            end
        endcase
    end

    // RAM: read on accept, write back at end of EXEC
    always_ff @(posedge i_clk) begin
        if (in_accept && idx_ok) begin
            r_mem_q <= r_mem[addr];
        end
        if (exec_done && n_mem_we) begin
            r_mem[addr] <= n_mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_mem_q_vld <= 1'b0;
            r_index     <= 8'h00;
            r_wprot     <= 1'b0;
            r_u20_b6    <= 1'b0;
            r_m23_b6    <= 1'b0;
            r_arch      <= crtc_pkg::ARCH_VGA;
            r_ign_hde   <= 1'b0;
            r_dscan     <= 1'b0;
            r_start     <= 16'h0000;
            r_cursor    <= 16'h0000;
            r_lcmp      <= 10'h000;
            r_shift     <= crtc_pkg::SHIFT_WORD;
            r_ltotal    <= 7'd1;
            r_rskip     <= 5'd0;
            r_bskip     <= 2'd0;
            r_cur_on    <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    crtc_pkg::CFG_ARCH_MODE:  r_arch    <= i_cfg_data[1:0];
                    crtc_pkg::CFG_IGNORE_HDE: r_ign_hde <= i_cfg_data[0];
                    crtc_pkg::CFG_DOUBLESCAN: r_dscan   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_state     <= ST_EXEC;
                r_mem_q_vld <= idx_ok && r_vld[addr];
            end
            if (exec_done) begin
                r_state     <= ST_IDLE;
                r_out_valid <= 1'b1;
                r_index     <= n_index;
                r_wprot     <= n_wprot;
                r_u20_b6    <= n_u20_b6;
                r_m23_b6    <= n_m23_b6;
                r_start     <= n_start;
                r_cursor    <= n_cursor;
                r_lcmp      <= n_lcmp;
                r_shift     <= n_shift;
                r_ltotal    <= n_ltotal;
                r_rskip     <= n_rskip;
                r_bskip     <= n_bskip;
                r_cur_on    <= n_cur_on;
                if (n_mem_we) begin
                    r_vld[addr] <= 1'b1;
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (exec_done) begin
            r_rd  <= n_rd;
            r_rs  <= n_rs;
            r_clr <= n_clr;
            r_unk <= n_unk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action <= i_action;
            r_wdata  <= i_write_data;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_rd;
    assign o_resize_request = r_rs;
    assign o_retrace_clear  = r_clr;
    assign o_unknown_index  = r_unk;
    assign o_start_addr     = r_start;
    assign o_cursor_address = r_cursor;
    assign o_split_line     = r_lcmp;
    assign o_addr_mode      = r_shift;
    assign o_row_lines      = r_ltotal;
    assign o_row_scan_skip  = r_rskip;
    assign o_byte_skip      = r_bskip;
    assign o_cursor_enabled = r_cur_on;

    // an accepted word always moves to EXEC
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_EXEC))
        else $error("accepted word did not enter EXEC");

    // EXEC holds while the result register is occupied and not taken
    a_exec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_out_valid && !i_out_ready) |=> (r_state == ST_EXEC))
        else $error("EXEC finished over a pending result");

    // unknown index reads zero and never resizes
    a_unknown_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unknown_index) |->
        (o_read_data == 8'h00 && o_resize_request == crtc_pkg::RS_NONE))
        else $error("unknown index produced data or resize");

    // resize code stays in range
    a_rs_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_resize_request <= crtc_pkg::RS_DEFERRED))
        else $error("bad resize code");

    // line total is never zero
    a_ltotal_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_row_lines != 7'd0)
        else $error("zero line total");

endmodule

`default_nettype wire
